// File: rtl/tiny_byte_isa_decode_execute_core_assert.svh
// Assertion helpers shared by the core.
`ifndef TINY_BYTE_ISA_DECODE_EXECUTE_CORE_ASSERT_SVH
`define TINY_BYTE_ISA_DECODE_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TBI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define TBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tbi_pkg.sv
package tbi_pkg;

	localparam int REG_COUNT = 4;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int DIV_STEPS = 8;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [5:0] TOP_IN  = 6'h30;
	localparam logic [5:0] TOP_OUT = 6'h31;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} alu_op_t;

	typedef enum logic [1:0] {
		KIND_OUT  = 2'd0,
		KIND_BAD  = 2'd1,
		KIND_DIV0 = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_WB
	} state_t;

	typedef struct packed {
		logic [7:0]        command;
		logic signed [7:0] in_value;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic signed [7:0] value;
	} res_t;

	typedef struct packed {
		logic load;
		logic exec_write;
		logic div_start;
		logic div_step;
		logic div_write;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic has_result;
		logic need_div;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

// File: rtl/tbi_datapath.sv
module tbi_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  tbi_pkg::item_t cmd,
	input  tbi_pkg::ctl_t  ctl,
	output tbi_pkg::stat_t stat,
	input  logic          res_ready,
	output logic          res_valid,
	output tbi_pkg::res_t  res
);
	import tbi_pkg::*;

	logic [7:0]           cmd_q;
	logic signed [7:0]    inval_q;
	logic [7:0]           mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [7:0]           rda_q, rdb_q;
	logic                 va_q, vb_q;
	logic [7:0]           a, b;

	logic                 is_movi, is_io, is_in, is_out, is_bad, is_alu, div_zero;
	alu_op_t              op;
	logic [REG_IDX_W-1:0] rd, rs;
	logic [15:0]          prod;
	logic [7:0]           alu_res;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_addr;
	logic [7:0]           wr_data;

	logic [7:0]           rem_q, quo_q, dvs_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [7:0]           shifted, mag_a, mag_b, quot;

	logic                 res_valid_q;
	res_t                 res_q, res_d;

	// latch the beat and read both operands from the register file
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd.command;
			inval_q <= cmd.in_value;
			rda_q   <= mem[cmd.command[3:2]];
			rdb_q   <= mem[cmd.command[1:0]];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (ctl.load) begin
				va_q <= vld_q[cmd.command[3:2]];
				vb_q <= vld_q[cmd.command[1:0]];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign a = va_q ? rda_q : 8'h00;
	assign b = vb_q ? rdb_q : 8'h00;

	assign rd       = cmd_q[3:2];
	assign rs       = cmd_q[1:0];
	assign op       = alu_op_t'(cmd_q[5:4]);
	assign is_movi  = !cmd_q[7];
	assign is_io    = cmd_q[7] && cmd_q[6];
	assign is_in    = cmd_q[7:2] == TOP_IN;
	assign is_out   = cmd_q[7:2] == TOP_OUT;
	assign is_bad   = is_io && !is_in && !is_out;
	assign is_alu   = cmd_q[7:6] == 2'b10;
	assign div_zero = is_alu && op == OP_DIV && b == 8'h00;

	assign prod = $signed(a) * $signed(b);

	always_comb begin
		case (op)
			OP_ADD:  alu_res = a + b;
			OP_SUB:  alu_res = a - b;
			OP_MUL:  alu_res = prod[7:0];
			default: alu_res = quot;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd;
		wr_data = alu_res;
		if (ctl.exec_write) begin
			wr_en = 1'b1;
			if (is_movi) begin
				wr_addr = REG_IDX_W'(REG_COUNT - 1);
				wr_data = {1'b0, cmd_q[6:0]};
			end else if (is_in) begin
				wr_addr = rs;
				wr_data = inval_q;
			end
		end else if (ctl.div_write) begin
			wr_en   = 1'b1;
			wr_data = quot;
		end
	end

	// restoring divider on magnitudes, one quotient bit per cycle
	assign mag_a   = a[7] ? 8'(~a + 8'd1) : a;
	assign mag_b   = b[7] ? 8'(~b + 8'd1) : b;
	assign shifted = {rem_q[6:0], quo_q[7]};
	assign quot    = neg_q ? 8'(~quo_q + 8'd1) : quo_q;

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			rem_q <= 8'h00;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= a[7] ^ b[7];
		end else if (ctl.div_step) begin
			if (shifted >= dvs_q) begin
				rem_q <= shifted - dvs_q;
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.div_start) begin
			cnt_q <= '0;
		end else if (ctl.div_step) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	always_comb begin
		res_d.value = 8'h00;
		if (is_out) begin
			res_d.kind  = KIND_OUT;
			res_d.value = b;
		end else if (is_bad) begin
			res_d.kind = KIND_BAD;
		end else begin
			res_d.kind = KIND_DIV0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign stat.has_result = is_out || is_bad || div_zero;
	assign stat.need_div   = is_alu && op == OP_DIV && b != 8'h00;
	assign stat.div_last   = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign stat.out_free   = !res_valid_q || res_ready;

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/tbi_controller.sv
module tbi_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tbi_pkg::stat_t stat,
	output tbi_pkg::ctl_t  ctl
);
	import tbi_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.has_result) begin
					if (stat.out_free) begin
						state_d = ST_IDLE;
					end
				end else if (stat.need_div) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (stat.div_last) begin
					state_d = ST_WB;
				end
			end
			ST_WB:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				ctl.load  = cmd_valid;
			end
			ST_EXEC: begin
				// a result beat holds here until the output slot can take it
				if (stat.has_result) begin
					ctl.emit = stat.out_free;
				end else if (stat.need_div) begin
					ctl.div_start = 1'b1;
				end else begin
					ctl.exec_write = 1'b1;
				end
			end
			ST_DIV:  ctl.div_step  = 1'b1;
			ST_WB:   ctl.div_write = 1'b1;
			default: ctl = '0;
		endcase
	end

endmodule

// File: rtl/tiny_byte_isa_decode_execute_core.sv
// A result beat (OUT, bad instruction, divide by zero) is emitted from the EXEC state after accept;
// EXEC holds while the output register still holds a beat that has not been taken.
// The core takes one item at a time and no new item until the last is done; a nonzero DIV runs accept, start,
// 8 restoring-divider steps (one quotient bit per cycle) and write-back.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low): registers read as zero through cleared valid bits, output empty.
`include "tiny_byte_isa_decode_execute_core_assert.svh"

module tiny_byte_isa_decode_execute_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tbi_pkg::item_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output tbi_pkg::res_t  res
);
	import tbi_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	tbi_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	tbi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.stat      (stat),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	`TBI_ASSERT_SAME(a_emit_free, clk, arst_n, ctl.emit, stat.out_free, "result overwritten")
	`TBI_ASSERT_NEXT(a_div_runs, clk, arst_n, ctl.div_start, ctl.div_step, "divider stalled")
	`TBI_ASSERT_NEXT(a_one_item, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready,
		"second item taken while busy")

endmodule

// File: dv/tbi_exec_checker.sv
module tbi_exec_checker
	import tbi_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	input  logic  cmd_ready,
	input  item_t cmd,
	input  logic  res_valid,
	input  logic  res_ready,
	input  res_t  res,
	output int    mismatches,
	output int    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [7:0] gpr [REG_COUNT];
	res_t result_q [$];
	int fail_total = 0;

	task automatic execute_command(input item_t it);
		logic [7:0] c;
		logic [1:0] rd;
		logic [1:0] rs;
		int a;
		int b;
		int r;
		res_t e;
		c = it.command;
		rd = c[3:2];
		rs = c[1:0];
		if (!c[7]) begin
			gpr[REG_COUNT-1] = {1'b0, c[6:0]};
		end else if (c[6]) begin
			if (c[7:2] == TOP_IN) begin
				gpr[rs] = it.in_value;
			end else if (c[7:2] == TOP_OUT) begin
				e.kind = KIND_OUT;
				e.value = gpr[rs];
				result_q.push_back(e);
			end else begin
				e.kind = KIND_BAD;
				e.value = '0;
				result_q.push_back(e);
			end
		end else begin
			// source is read before the destination is written
			a = gpr[rd];
			b = gpr[rs];
			r = a;
			case (alu_op_t'(c[5:4]))
				OP_ADD: r = a + b;
				OP_SUB: r = a - b;
				OP_MUL: r = a * b;
				OP_DIV: begin
					if (b == 0) begin
						e.kind = KIND_DIV0;
						e.value = '0;
						result_q.push_back(e);
					end else begin
						r = a / b;
					end
				end
				default: r = a;
			endcase
			gpr[rd] = r[7:0];
		end
	endtask

	task automatic compare_result(input res_t got);
		res_t want;
		if (result_q.size() == 0) begin
			fail_total++;
			$display("%0t: unexpected result beat, got kind %0d value %0d",
				$time, got.kind, got.value);
		end else begin
			want = result_q.pop_front();
			if (got.kind !== want.kind) begin
				fail_total++;
				$display("%0t: kind mismatch, expected %0d got %0d",
					$time, want.kind, got.kind);
			end
			if (got.value !== want.value) begin
				fail_total++;
				$display("%0t: value mismatch, expected %0d got %0d",
					$time, want.value, got.value);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (gpr[i]) gpr[i] = '0;
			result_q.delete();
			outstanding <= 0;
			mismatches <= fail_total;
		end else begin
			if (cmd_valid && cmd_ready)
				execute_command(cmd);
			if (res_valid && res_ready)
				compare_result(res);
			outstanding <= result_q.size();
			mismatches <= fail_total;
		end
	end

endmodule

// File: dv/tb_top.sv
module tb_top;
	import tbi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 450;
	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT = 100000;
	localparam logic [1:0] ALU_PREFIX = 2'b10;
	localparam logic [5:0] TOP_BAD_FIRST = TOP_OUT + 6'd1;
	localparam logic [5:0] TOP_BAD_LAST = 6'h3F;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_ready;
	item_t cmd = '0;
	logic  res_valid;
	logic  res_ready = 1'b0;
	res_t  res;
	int    mismatches;
	int    outstanding;

	tiny_byte_isa_decode_execute_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	tbi_exec_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic item_t make_item(input logic [7:0] c, input logic signed [7:0] v);
		item_t it;
		it.command = c;
		it.in_value = v;
		return it;
	endfunction

	function automatic logic [7:0] movi_cmd(input logic [6:0] imm);
		return {1'b0, imm};
	endfunction

	function automatic logic [7:0] in_cmd(input logic [1:0] r);
		return {TOP_IN, r};
	endfunction

	function automatic logic [7:0] out_cmd(input logic [1:0] r);
		return {TOP_OUT, r};
	endfunction

	function automatic logic [7:0] alu_cmd(input alu_op_t op, input logic [1:0] rd,
		input logic [1:0] rs);
		return {ALU_PREFIX, op, rd, rs};
	endfunction

	// bias toward zero and the extremes so divide by zero and overflow recur
	function automatic logic signed [7:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 8'sd0;
			1: return -8'sd128;
			2: return 8'sd127;
			3: return -8'sd1;
			4: return 8'sd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send(input item_t it, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 99) < 10) begin
			gap = $urandom_range(1, 5);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= it;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
	endtask

	initial begin
		int cyc;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= CYCLE_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// receiver: random stalls, one clean stretch, one long hold-off
	initial begin
		int cyc;
		bit rdy;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= 400 && cyc < 600)
				rdy = 1'b0;
			else if (cyc >= 150 && cyc < 300)
				rdy = 1'b1;
			else
				rdy = $urandom_range(0, 99) >= 10;
			res_ready <= rdy;
		end
	end

	initial begin
		item_t it;
		int sel;
		logic [7:0] c;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(make_item(movi_cmd(7'h00), 8'sd5), 1'b1);
		send(make_item(movi_cmd(7'h7F), -8'sd1), 1'b1);
		send(make_item(out_cmd(2'd3), 8'sd0), 1'b1);
		send(make_item(in_cmd(2'd0), -8'sd128), 1'b1);
		send(make_item(in_cmd(2'd1), -8'sd1), 1'b1);
		send(make_item(in_cmd(2'd2), 8'sd0), 1'b1);
		send(make_item(in_cmd(2'd3), 8'sd127), 1'b1);
		send(make_item(out_cmd(2'd0), 8'sd0), 1'b1);
		send(make_item(out_cmd(2'd1), 8'sd0), 1'b1);
		send(make_item(out_cmd(2'd2), 8'sd0), 1'b1);
		// -128 / -1 wraps back to -128
		send(make_item(alu_cmd(OP_DIV, 2'd0, 2'd1), 8'sd0), 1'b1);
		send(make_item(out_cmd(2'd0), 8'sd0), 1'b1);
		send(make_item(alu_cmd(OP_DIV, 2'd1, 2'd2), 8'sd0), 1'b1);
		send(make_item(out_cmd(2'd1), 8'sd0), 1'b1);
		send(make_item(alu_cmd(OP_ADD, 2'd3, 2'd3), 8'sd0), 1'b1);
		send(make_item(out_cmd(2'd3), 8'sd0), 1'b1);
		send(make_item(alu_cmd(OP_SUB, 2'd2, 2'd0), 8'sd0), 1'b1);
		send(make_item(alu_cmd(OP_MUL, 2'd0, 2'd1), 8'sd0), 1'b1);
		send(make_item(alu_cmd(OP_MUL, 2'd3, 2'd3), 8'sd0), 1'b1);
		send(make_item(alu_cmd(OP_DIV, 2'd3, 2'd0), 8'sd0), 1'b1);
		send(make_item({TOP_BAD_FIRST, 2'd0}, 8'sd0), 1'b1);
		send(make_item({TOP_BAD_LAST, 2'd3}, -8'sd128), 1'b1);
		send(make_item(out_cmd(2'd2), 8'sd0), 1'b1);
		send(make_item(out_cmd(2'd3), 8'sd0), 1'b1);
		send(make_item(out_cmd(2'd0), 8'sd0), 1'b1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 15)
				c = movi_cmd(7'($urandom_range(0, 127)));
			else if (sel < 35)
				c = in_cmd(2'($urandom_range(0, 3)));
			else if (sel < 60)
				c = out_cmd(2'($urandom_range(0, 3)));
			else if (sel < 90)
				c = alu_cmd(alu_op_t'(2'($urandom_range(0, 3))), 2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)));
			else
				c = {6'($urandom_range(TOP_BAD_FIRST, TOP_BAD_LAST)), 2'($urandom_range(0, 3))};
			it = make_item(c, pick_value());
			send(it, !(n >= 150 && n < 260));
		end
		cmd_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
